FILE: hw/rtl/rsds_pkg.sv
package rsds_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 8;
    localparam int CFG_W = 7;
    localparam int IDX_W = 2;

    // fraction bits of the length, ratio and interpolation values
    localparam int Q_BITS = 16;

    localparam int PCT       = 100;
    localparam int NEAR_ZERO = 10;
    localparam int DZ_SCALE  = 10000;
    localparam int SAT_PAD   = 10;

    localparam logic [CFG_W-1:0] DEADZONE_RST = 7'd10;
    localparam logic [CFG_W-1:0] AXIS_SAT_RST = 7'd100;
    localparam logic [CFG_W-1:0] DIAG_SAT_RST = 7'd100;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEADZONE = 2'd0,
        CFG_AXIS_SAT = 2'd1,
        CFG_DIAG_SAT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [IN_W-1:0] raw_x;
        logic signed [IN_W-1:0] raw_y;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] scaled_x;
        logic signed [OUT_W-1:0] scaled_y;
    } result_t;

endpackage

FILE: hw/rtl/radial_stick_deadzone_scaler.sv
// radial deadzone and saturation scaling of one x/y stick item per clock
// throughput: one item every cycle, set by the root, ratio and divide cell rows
// busy stays low and results cannot be held off; every item gives one result
// reset: async active low clears the strobe line and loads the default percentages
module radial_stick_deadzone_scaler #(
    parameter int AXIS_BITS = 16,
    parameter int OUT_FULL  = 100
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  rsds_pkg::sample_t                     sample,
    output logic                                  done,
    output rsds_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rsds_pkg::IDX_W-1:0]            cfg_index,
    input  logic [rsds_pkg::CFG_W-1:0]            cfg_data
);

    localparam int CW     = rsds_pkg::CFG_W;
    localparam int QB     = rsds_pkg::Q_BITS;
    localparam int FW     = AXIS_BITS - 1;
    localparam int FULL   = (1 << (AXIS_BITS - 1)) - 1;
    localparam int MB     = $clog2(OUT_FULL + 1);
    localparam int AW     = rsds_pkg::IN_W;
    localparam int AO_W   = AW + MB;
    localparam int DL_W   = CW + FW;
    localparam int SQ_W   = 2 * AW;
    localparam int ZP_W   = SQ_W + 14;
    localparam int ROOT_W = SQ_W;
    localparam int R_W    = QB + 1;
    localparam int SAT_W  = CW + QB + 3;
    localparam int L_W    = ROOT_W + 7;
    localparam int D_W    = CW + QB;
    localparam int DEN_W  = D_W + FW;
    localparam int TR_W   = DEN_W + 1;
    localparam int T_W    = QB + 1;
    localparam int MD_W   = 2 * AW - 1 + MB;
    localparam int MR_W   = MD_W + 1;

    localparam int ROOT_N = ROOT_W;
    localparam int RAT_N  = R_W;
    localparam int TDIV_N = T_W;
    localparam int P_LEN  = 1 + ROOT_N;
    localparam int P_RAT  = 1 + RAT_N;
    localparam int RD_N   = P_LEN - P_RAT;
    localparam int P_SAT  = P_LEN + 1;
    localparam int P_NUM  = P_SAT + 1;
    localparam int P_DEN  = P_NUM + 1;
    localparam int P_TDIV = P_DEN + 1;
    localparam int P_TQ   = P_TDIV + TDIV_N;
    localparam int P_T    = P_TQ + 1;
    localparam int P_N    = P_T + 1;
    localparam int P_MQ   = P_N + MB;
    localparam int P_OUT  = P_MQ + 1;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << QB;

    typedef struct packed {
        logic            zero;
        logic            tsat;
        logic            sx;
        logic            sy;
        logic [AW-1:0]   peak;
        logic [AO_W-1:0] aox;
        logic [AO_W-1:0] aoy;
        logic [DL_W-1:0] dlim;
    } ctx_t;

    logic [CW-1:0]      dz_reg;
    logic [CW-1:0]      axis_reg;
    logic [CW-1:0]      diag_reg;

    logic [P_OUT:0]     v_reg;
    rsds_pkg::sample_t  in_reg;
    ctx_t               ctx_reg [1:P_MQ];
    ctx_t               ctx_c;
    logic [SQ_W-1:0]    sq_reg;
    logic [AW-1:0]      least_reg;
    logic [SQ_W-1:0]    sq_c;
    logic [AW-1:0]      least_c;
    logic               zero_c;

    logic [R_W-1:0]     r_dly [0:RD_N-1];

    logic signed [SAT_W-1:0] sat_reg;
    logic signed [SAT_W-1:0] sat_c;
    logic [L_W-1:0]     len100_reg;
    logic [D_W-1:0]     d_reg;
    logic [D_W-1:0]     d_c;
    logic [L_W-1:0]     num_reg;
    logic [L_W-1:0]     num_c;
    logic [L_W-1:0]     num36_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [L_W-1:0]     num37_reg;
    logic [DEN_W-1:0]   den37_reg;
    logic               tsat_c;
    logic [T_W-1:0]     t_reg;
    logic [T_W-1:0]     t_c;
    logic [MR_W-1:0]    nx_reg;
    logic [MR_W-1:0]    ny_reg;
    logic [MD_W-1:0]    mdiv_reg;
    rsds_pkg::result_t  result_reg;
    rsds_pkg::result_t  result_c;

    logic [SQ_W-1:0]    rad_w  [0:ROOT_N];
    logic [ROOT_W+3:0]  rrem_w [0:ROOT_N];
    logic [ROOT_W-1:0]  root_w [0:ROOT_N];

    logic [R_W-1:0]     arem_w [0:RAT_N];
    logic [AW-1:0]      adiv_w [0:RAT_N];
    logic [R_W-1:0]     aquo_w [0:RAT_N];

    logic [TR_W-1:0]    trem_w [0:TDIV_N];
    logic [DEN_W-1:0]   tdiv_w [0:TDIV_N];
    logic [T_W-1:0]     tquo_w [0:TDIV_N];

    logic [MR_W-1:0]    xrem_w [0:MB];
    logic [MD_W-1:0]    xdiv_w [0:MB];
    logic [MB-1:0]      xquo_w [0:MB];
    logic [MR_W-1:0]    yrem_w [0:MB];
    logic [MD_W-1:0]    ydiv_w [0:MB];
    logic [MB-1:0]      yquo_w [0:MB];

    function automatic logic [rsds_pkg::OUT_W-1:0] finish(
        input logic [MB-1:0] q,
        input logic          neg,
        input logic          zero
    );
        logic [rsds_pkg::OUT_W-1:0] mag;
        mag = (32'(q) > OUT_FULL) ? rsds_pkg::OUT_W'(OUT_FULL) : rsds_pkg::OUT_W'(q);
        if (zero)
        begin
            mag = '0;
        end
        return neg ? rsds_pkg::OUT_W'(-mag) : mag;
    endfunction

    function automatic ctx_t with_zero(input ctx_t c, input logic z);
        ctx_t r;
        r      = c;
        r.zero = z;
        return r;
    endfunction

    function automatic ctx_t with_tsat(input ctx_t c, input logic s);
        ctx_t r;
        r      = c;
        r.tsat = s;
        return r;
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = v_reg[P_OUT];
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg   <= rsds_pkg::DEADZONE_RST;
            axis_reg <= rsds_pkg::AXIS_SAT_RST;
            diag_reg <= rsds_pkg::DIAG_SAT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rsds_pkg::CFG_DEADZONE: dz_reg   <= cfg_data;
                rsds_pkg::CFG_AXIS_SAT: axis_reg <= cfg_data;
                rsds_pkg::CFG_DIAG_SAT: diag_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[P_OUT-1:0], start};
        end
    end

    // magnitudes, squared length and the deadzone limit
    always_comb
    begin
        logic [AW-1:0] ax;
        logic [AW-1:0] ay;
        ax = in_reg.raw_x[AW-1] ? AW'(-in_reg.raw_x) : AW'(in_reg.raw_x);
        ay = in_reg.raw_y[AW-1] ? AW'(-in_reg.raw_y) : AW'(in_reg.raw_y);
        sq_c       = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
        least_c    = (ax > ay) ? ay : ax;
        ctx_c.zero = 1'b0;
        ctx_c.tsat = 1'b0;
        ctx_c.sx   = in_reg.raw_x[AW-1];
        ctx_c.sy   = in_reg.raw_y[AW-1];
        ctx_c.peak = (ax > ay) ? ax : ay;
        ctx_c.aox  = AO_W'(ax) * AO_W'(OUT_FULL);
        ctx_c.aoy  = AO_W'(ay) * AO_W'(OUT_FULL);
        ctx_c.dlim = DL_W'(dz_reg) * DL_W'(FULL);
    end

    assign zero_c = (sq_reg <= SQ_W'(rsds_pkg::NEAR_ZERO))
                 || (ZP_W'(sq_reg) * ZP_W'(rsds_pkg::DZ_SCALE)
                     <= ZP_W'(ctx_reg[1].dlim) * ZP_W'(ctx_reg[1].dlim));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= sample;
        end
        sq_reg     <= sq_c;
        least_reg  <= least_c;
        ctx_reg[1] <= ctx_c;
        for (int k = 2; k <= P_MQ; k++)
        begin
            if (k == 2)
            begin
                ctx_reg[k] <= with_zero(ctx_reg[k-1], zero_c);
            end
            else if (k == P_TDIV)
            begin
                ctx_reg[k] <= with_tsat(ctx_reg[k-1], tsat_c);
            end
            else
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // length: one square root digit per cell
    assign rad_w[0]  = sq_reg;
    assign rrem_w[0] = '0;
    assign root_w[0] = '0;

    for (genvar g = 0; g < ROOT_N; g++)
    begin : g_root
        rsds_root_cell #(
            .RAD_W  (SQ_W),
            .ROOT_W (ROOT_W)
        ) u_cell (
            .clk      (clk),
            .rad_in   (rad_w[g]),
            .rem_in   (rrem_w[g]),
            .root_in  (root_w[g]),
            .rad_out  (rad_w[g+1]),
            .rem_out  (rrem_w[g+1]),
            .root_out (root_w[g+1])
        );
    end

    // least / peak ratio, one quotient bit per cell
    assign arem_w[0] = R_W'(least_reg);
    assign adiv_w[0] = ctx_reg[1].peak;
    assign aquo_w[0] = '0;

    for (genvar g = 0; g < RAT_N; g++)
    begin : g_rat
        rsds_div_cell #(
            .RW (R_W),
            .DW (AW),
            .QW (R_W)
        ) u_cell (
            .clk     (clk),
            .rem_in  (arem_w[g]),
            .div_in  (adiv_w[g]),
            .quo_in  (aquo_w[g]),
            .rem_out (arem_w[g+1]),
            .div_out (adiv_w[g+1]),
            .quo_out (aquo_w[g+1])
        );
    end

    always_ff @(posedge clk)
    begin
        r_dly[0] <= aquo_w[RAT_N];
        for (int k = 1; k < RD_N; k++)
        begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // saturation radius, distance past the deadzone and the t divide operands
    always_comb
    begin
        logic signed [SAT_W-1:0] diff;
        logic signed [SAT_W-1:0] dead;
        logic [L_W-1:0]          dl_sh;
        diff   = SAT_W'(diag_reg) - SAT_W'(axis_reg);
        sat_c  = (SAT_W'(axis_reg) << QB) + diff * SAT_W'(r_dly[RD_N-1]);
        dead   = SAT_W'(dz_reg) << QB;
        d_c    = (sat_reg <= dead) ? (D_W'(rsds_pkg::SAT_PAD) << QB) : D_W'(sat_reg - dead);
        dl_sh  = L_W'(ctx_reg[P_SAT].dlim) << QB;
        num_c  = (len100_reg > dl_sh) ? (len100_reg - dl_sh) : '0;
        tsat_c = ((L_W+1)'(num36_reg) >= ((L_W+1)'(den_reg) << 1));
    end

    always_ff @(posedge clk)
    begin
        sat_reg    <= sat_c;
        len100_reg <= L_W'(root_w[ROOT_N]) * L_W'(rsds_pkg::PCT);
        d_reg      <= d_c;
        num_reg    <= num_c;
        den_reg    <= DEN_W'(d_reg) * DEN_W'(FULL);
        num36_reg  <= num_reg;
        den37_reg  <= den_reg;
        num37_reg  <= num36_reg;
    end

    assign trem_w[0] = TR_W'(num37_reg);
    assign tdiv_w[0] = den37_reg;
    assign tquo_w[0] = '0;

    for (genvar g = 0; g < TDIV_N; g++)
    begin : g_tdiv
        rsds_div_cell #(
            .RW (TR_W),
            .DW (DEN_W),
            .QW (T_W)
        ) u_cell (
            .clk     (clk),
            .rem_in  (trem_w[g]),
            .div_in  (tdiv_w[g]),
            .quo_in  (tquo_w[g]),
            .rem_out (trem_w[g+1]),
            .div_out (tdiv_w[g+1]),
            .quo_out (tquo_w[g+1])
        );
    end

    assign t_c = (ctx_reg[P_TQ].tsat || tquo_w[TDIV_N] > T_ONE) ? T_ONE : tquo_w[TDIV_N];

    // rounded per-axis numerators, half a peak unit added before the divide
    always_ff @(posedge clk)
    begin
        t_reg    <= t_c;
        nx_reg   <= MR_W'(ctx_reg[P_T].aox) * MR_W'(t_reg)
                    + (MR_W'(ctx_reg[P_T].peak) << (QB - 1));
        ny_reg   <= MR_W'(ctx_reg[P_T].aoy) * MR_W'(t_reg)
                    + (MR_W'(ctx_reg[P_T].peak) << (QB - 1));
        mdiv_reg <= MD_W'(ctx_reg[P_T].peak) << (QB - 1 + MB);
    end

    assign xrem_w[0] = nx_reg;
    assign xdiv_w[0] = mdiv_reg;
    assign xquo_w[0] = '0;
    assign yrem_w[0] = ny_reg;
    assign ydiv_w[0] = mdiv_reg;
    assign yquo_w[0] = '0;

    for (genvar g = 0; g < MB; g++)
    begin : g_mag
        rsds_div_cell #(
            .RW (MR_W),
            .DW (MD_W),
            .QW (MB)
        ) u_xcell (
            .clk     (clk),
            .rem_in  (xrem_w[g]),
            .div_in  (xdiv_w[g]),
            .quo_in  (xquo_w[g]),
            .rem_out (xrem_w[g+1]),
            .div_out (xdiv_w[g+1]),
            .quo_out (xquo_w[g+1])
        );

        rsds_div_cell #(
            .RW (MR_W),
            .DW (MD_W),
            .QW (MB)
        ) u_ycell (
            .clk     (clk),
            .rem_in  (yrem_w[g]),
            .div_in  (ydiv_w[g]),
            .quo_in  (yquo_w[g]),
            .rem_out (yrem_w[g+1]),
            .div_out (ydiv_w[g+1]),
            .quo_out (yquo_w[g+1])
        );
    end

    always_comb
    begin
        result_c.scaled_x = finish(xquo_w[MB], ctx_reg[P_MQ].sx, ctx_reg[P_MQ].zero);
        result_c.scaled_y = finish(yquo_w[MB], ctx_reg[P_MQ].sy, ctx_reg[P_MQ].zero);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_c;
    end

endmodule

FILE: hw/rtl/rsds_div_cell.sv
module rsds_div_cell #(
    parameter int RW = 17,
    parameter int DW = 16,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic [RW-1:0] rem_in,
    input  logic [DW-1:0] div_in,
    input  logic [QW-1:0] quo_in,
    output logic [RW-1:0] rem_out,
    output logic [DW-1:0] div_out,
    output logic [QW-1:0] quo_out
);

    logic [RW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [QW-1:0] quo_reg;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] quo_next;
    logic [RW-1:0] diff;
    logic          ge;

    // one restoring step: compare, subtract, then double the remainder
    always_comb
    begin
        ge       = (rem_in >= RW'(div_in));
        diff     = ge ? (rem_in - RW'(div_in)) : rem_in;
        rem_next = {diff[RW-2:0], 1'b0};
        quo_next = QW'({quo_in, ge});
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_in;
        quo_reg <= quo_next;
    end

    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign quo_out = quo_reg;

endmodule

FILE: hw/rtl/rsds_root_cell.sv
module rsds_root_cell #(
    parameter int RAD_W  = 32,
    parameter int ROOT_W = 32
) (
    input  logic                clk,
    input  logic [RAD_W-1:0]    rad_in,
    input  logic [ROOT_W+3:0]   rem_in,
    input  logic [ROOT_W-1:0]   root_in,
    output logic [RAD_W-1:0]    rad_out,
    output logic [ROOT_W+3:0]   rem_out,
    output logic [ROOT_W-1:0]   root_out
);

    localparam int RW = ROOT_W + 4;

    logic [RAD_W-1:0]  rad_reg;
    logic [RW-1:0]     rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [RW-1:0]     rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [RW-1:0]     remx;
    logic [RW-1:0]     trial;
    logic              ge;

    // one digit pair per cell, zeros follow once the radicand is used up
    always_comb
    begin
        remx      = {rem_in[RW-3:0], rad_in[RAD_W-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        ge        = (remx >= trial);
        rem_next  = ge ? (remx - trial) : remx;
        root_next = {root_in[ROOT_W-2:0], ge};
        rad_next  = {rad_in[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule
